// ===== rtl/abbr_pkg.sv =====
`timescale 1ns / 1ps
package abbr_pkg;

  localparam int MAX_BANDS  = 8;
  localparam int BAND_IDX_W = $clog2(MAX_BANDS);
  localparam int BAND_CNT_W = $clog2(MAX_BANDS + 1);
  localparam int HEIGHT_W   = 32;
  localparam int ALU_W      = HEIGHT_W + 2;   // room for 33-bit magnitudes, signed
  localparam int DIST_W     = HEIGHT_W + 1;
  localparam int WEIGHT_W   = 17;
  localparam int DIV_STEPS  = WEIGHT_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAND_COUNT    = 2'd0,
    REG_WATER_VISIBLE = 2'd1,
    REG_WATER_LEVEL   = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WATER_PREV,
    ST_WATER_CUR,
    ST_PRIM_FLOOR,
    ST_PRIM_CEIL,
    ST_BUF_CHECK,
    ST_NB_FLOOR,
    ST_NB_CEIL,
    ST_NB_CMP,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [HEIGHT_W-1:0] floor_h;
    logic [HEIGHT_W-1:0] ceil_h;
    logic                ceil_open;
    logic [HEIGHT_W-1:0] buffer;
  } band_entry_t;

  // input word, lowest field last
  typedef struct packed {
    logic [2:0]            pad;
    logic                  teleported;
    logic [HEIGHT_W-1:0]   previous_height;
    logic [HEIGHT_W-1:0]   height;
    logic [HEIGHT_W-1:0]   transition_width;
    logic                  ceiling_open;
    logic [HEIGHT_W-1:0]   ceiling_height;
    logic [HEIGHT_W-1:0]   floor_height;
    logic [BAND_IDX_W-1:0] band_index;
  } in_word_t;

  typedef struct packed {
    logic [6:0]            pad;
    logic [WEIGHT_W-1:0]   neighbor_weight;
    logic [BAND_IDX_W-1:0] neighbor_band;
    logic                  neighbor_valid;
    logic                  instant_cut;
    logic [BAND_IDX_W-1:0] primary_band;
  } out_word_t;

  typedef struct packed {
    logic [ALU_W-1:0]  diff;
    logic              lt;
    logic [DIST_W-1:0] mag;
  } cmp_res_t;

  function automatic logic [ALU_W-1:0] sext_h(input logic [HEIGHT_W-1:0] v);
    sext_h = {{(ALU_W-HEIGHT_W){v[HEIGHT_W-1]}}, v};
  endfunction

  function automatic logic [ALU_W-1:0] zext_d(input logic [DIST_W-1:0] v);
    zext_d = {{(ALU_W-DIST_W){1'b0}}, v};
  endfunction

endpackage

// ===== rtl/abbr_band_table.sv =====
`timescale 1ns / 1ps
module abbr_band_table import abbr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  we_i,
  input  logic [BAND_IDX_W-1:0] waddr_i,
  input  band_entry_t           wentry_i,
  input  logic [BAND_IDX_W-1:0] raddr_i,
  output band_entry_t           rentry_o
);

  band_entry_t tbl_q [MAX_BANDS];

  // reset leaves every band with an open ceiling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_BANDS; i++) begin
        tbl_q[i] <= '{floor_h: '0, ceil_h: '0, ceil_open: 1'b1, buffer: '0};
      end
    end else if (we_i) begin
      tbl_q[waddr_i] <= wentry_i;
    end
  end

  assign rentry_o = tbl_q[raddr_i];

endmodule

// ===== rtl/abbr_cmp_unit.sv =====
`timescale 1ns / 1ps
module abbr_cmp_unit import abbr_pkg::*; (
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  output cmp_res_t         res_o
);

  logic [ALU_W-1:0] diff;
  logic [ALU_W-1:0] neg;

  // operands never use the top bit range, so a - b cannot overflow
  assign diff = a_i - b_i;
  assign neg  = '0 - diff;

  assign res_o.diff = diff;
  assign res_o.lt   = diff[ALU_W-1];
  assign res_o.mag  = diff[ALU_W-1] ? neg[DIST_W-1:0] : diff[DIST_W-1:0];

endmodule

// ===== rtl/altitude_band_blend_resolver.sv =====
`timescale 1ns / 1ps
// Altitude band blend resolver.
// Input words arrive on s_axis. tuser selects the word kind: a load writes one
// band entry into the 8-entry table in the accept cycle and gives no output
// word; a query gives exactly one output word on m_axis.
// A query runs under a sequencer that drives one shared 34-bit subtract and
// compare unit: the water plane test compares the previous and the current
// height against the level; the primary band scan tests the floor and, for a
// closed ceiling, the ceiling of each band, then an end test; the nearest
// boundary scan takes floor and closed ceiling of each band (distance, then
// compare against the best), skips the primary and ends with an end test;
// then buffer minus distance is formed, and seventeen restoring division
// steps give the Q1.16 weight. A cut or a disabled buffer skips the neighbor
// scan. s_axis_tready is high only in idle, so the next word goes in the
// cycle after the result is loaded; a load leaves the sequencer in idle.
// The result sits in an output register, so a new word is taken while the
// previous result waits; a stalled receiver holds the next query in its last
// state until the output register frees up.
// Config writes (cfg_we_i) are registered and should only occur when idle.
// Reset: band_count 1, water off, level 0, all entries zero, ceilings open.
module altitude_band_blend_resolver import abbr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // fields from bit 0: band_index, floor_height, ceiling_height, ceiling_open,
  // transition_width, height, previous_height, teleported, zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,   // operation
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // fields from bit 0: primary_band, instant_cut, neighbor_valid,
  // neighbor_band, neighbor_weight, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // config registers
  logic [BAND_CNT_W-1:0] band_count_q;
  logic                  water_visible_q;
  logic [HEIGHT_W-1:0]   water_level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_count_q    <= BAND_CNT_W'(1);
      water_visible_q <= 1'b0;
      water_level_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BAND_COUNT:    band_count_q    <= cfg_data_i[BAND_CNT_W-1:0];
        REG_WATER_VISIBLE: water_visible_q <= cfg_data_i[0];
        REG_WATER_LEVEL:   water_level_q   <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // bands in use: zero counts as one, saturate at table depth
  logic [BAND_CNT_W-1:0] n_bands;
  always_comb begin
    if (band_count_q == '0) begin
      n_bands = BAND_CNT_W'(1);
    end else if (band_count_q > BAND_CNT_W'(MAX_BANDS)) begin
      n_bands = BAND_CNT_W'(MAX_BANDS);
    end else begin
      n_bands = band_count_q;
    end
  end

  in_word_t in_w;
  assign in_w = in_word_t'(s_axis_tdata);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // band table
  logic                  tbl_we;
  band_entry_t           tbl_wentry;
  logic [BAND_IDX_W-1:0] tbl_raddr;
  band_entry_t           rd;

  assign tbl_we     = in_acc && (op_e'(s_axis_tuser) == OP_LOAD);
  assign tbl_wentry = '{floor_h: in_w.floor_height, ceil_h: in_w.ceiling_height,
                        ceil_open: in_w.ceiling_open, buffer: in_w.transition_width};

  abbr_band_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (tbl_we),
    .waddr_i  (in_w.band_index),
    .wentry_i (tbl_wentry),
    .raddr_i  (tbl_raddr),
    .rentry_o (rd)
  );

  // shared subtract/compare unit
  logic [ALU_W-1:0] cmp_a;
  logic [ALU_W-1:0] cmp_b;
  cmp_res_t         cmp;

  abbr_cmp_unit u_cmp (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp)
  );

  // sequencer state and working registers
  state_e                state_q, state_d;
  logic [BAND_CNT_W-1:0] idx_q, idx_d;
  logic [HEIGHT_W-1:0]   h_q, h_d;
  logic [HEIGHT_W-1:0]   ph_q, ph_d;
  logic                  cut_q, cut_d;
  logic                  ph_ge_q, ph_ge_d;
  logic [BAND_IDX_W-1:0] primary_q, primary_d;
  logic                  found_q, found_d;
  logic [DIST_W-1:0]     best_q, best_d;
  logic [BAND_IDX_W-1:0] near_band_q, near_band_d;
  logic [DIST_W-1:0]     dist_q, dist_d;
  logic                  cmp_floor_q, cmp_floor_d;
  logic [DIST_W-1:0]     rem_q, rem_d;
  logic [WEIGHT_W-1:0]   quot_q, quot_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  nb_valid_q, nb_valid_d;
  logic                  out_valid_q, out_valid_d;
  out_word_t             out_q, out_d;

  logic idx_end;
  logic out_free;
  logic buf_off;
  logic take;
  logic div_go;
  logic step_last;

  assign idx_end   = idx_q >= n_bands;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign buf_off   = rd.buffer[HEIGHT_W-1] || (rd.buffer == '0);
  assign take      = cmp_floor_q ? (!found_q || cmp.lt) : cmp.lt;
  assign div_go    = found_q && !cmp.lt && (cmp.diff != '0);
  assign step_last = step_q == STEP_W'(DIV_STEPS - 1);

  always_comb begin
    unique case (state_q) inside
      ST_BUF_CHECK, ST_DIV_INIT, ST_DIV_STEP: tbl_raddr = primary_q;
      default:                                tbl_raddr = idx_q[BAND_IDX_W-1:0];
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_e'(s_axis_tuser) == OP_QUERY)) state_d = ST_WATER_PREV;
      end
      ST_WATER_PREV: state_d = ST_WATER_CUR;
      ST_WATER_CUR:  state_d = ST_PRIM_FLOOR;
      ST_PRIM_FLOOR: begin
        if (idx_end) begin
          state_d = ST_BUF_CHECK;
        end else if (!cmp.lt) begin
          state_d = rd.ceil_open ? ST_BUF_CHECK : ST_PRIM_CEIL;
        end
      end
      ST_PRIM_CEIL: state_d = cmp.lt ? ST_BUF_CHECK : ST_PRIM_FLOOR;
      ST_BUF_CHECK: state_d = (cut_q || buf_off) ? ST_DONE : ST_NB_FLOOR;
      ST_NB_FLOOR: begin
        if (idx_end) begin
          state_d = ST_DIV_INIT;
        end else if (idx_q[BAND_IDX_W-1:0] != primary_q) begin
          state_d = ST_NB_CMP;
        end
      end
      ST_NB_CEIL: state_d = ST_NB_CMP;
      ST_NB_CMP:  state_d = (cmp_floor_q && !rd.ceil_open) ? ST_NB_CEIL : ST_NB_FLOOR;
      ST_DIV_INIT: state_d = div_go ? ST_DIV_STEP : ST_DONE;
      ST_DIV_STEP: begin
        if (step_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_d       = idx_q;
    h_d         = h_q;
    ph_d        = ph_q;
    cut_d       = cut_q;
    ph_ge_d     = ph_ge_q;
    primary_d   = primary_q;
    found_d     = found_q;
    best_d      = best_q;
    near_band_d = near_band_q;
    dist_d      = dist_q;
    cmp_floor_d = cmp_floor_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    step_d      = step_q;
    nb_valid_d  = nb_valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    cmp_a       = '0;
    cmp_b       = '0;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        h_d   = in_w.height;
        ph_d  = in_w.previous_height;
        cut_d = in_w.teleported;
      end
      ST_WATER_PREV: begin
        cmp_a   = sext_h(ph_q);
        cmp_b   = sext_h(water_level_q);
        ph_ge_d = !cmp.lt;
      end
      ST_WATER_CUR: begin
        cmp_a = sext_h(h_q);
        cmp_b = sext_h(water_level_q);
        if (water_visible_q && (ph_ge_q == cmp.lt)) cut_d = 1'b1;
        idx_d     = BAND_CNT_W'(1);
        primary_d = '0;
      end
      ST_PRIM_FLOOR: begin
        cmp_a = sext_h(h_q);
        cmp_b = sext_h(rd.floor_h);
        if (!idx_end) begin
          if (cmp.lt) begin
            idx_d = idx_q + 1'b1;
          end else if (rd.ceil_open) begin
            primary_d = idx_q[BAND_IDX_W-1:0];
          end
        end
      end
      ST_PRIM_CEIL: begin
        cmp_a = sext_h(h_q);
        cmp_b = sext_h(rd.ceil_h);
        if (cmp.lt) begin
          primary_d = idx_q[BAND_IDX_W-1:0];
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_BUF_CHECK: begin
        nb_valid_d  = 1'b0;
        idx_d       = '0;
        found_d     = 1'b0;
        best_d      = '0;
        near_band_d = '0;
      end
      ST_NB_FLOOR: begin
        cmp_a       = sext_h(h_q);
        cmp_b       = sext_h(rd.floor_h);
        dist_d      = cmp.mag;
        cmp_floor_d = 1'b1;
        if (!idx_end && (idx_q[BAND_IDX_W-1:0] == primary_q)) idx_d = idx_q + 1'b1;
      end
      ST_NB_CEIL: begin
        cmp_a       = sext_h(h_q);
        cmp_b       = sext_h(rd.ceil_h);
        dist_d      = cmp.mag;
        cmp_floor_d = 1'b0;
      end
      ST_NB_CMP: begin
        // strict less keeps the earlier band and the floor on ties
        cmp_a = zext_d(dist_q);
        cmp_b = zext_d(best_q);
        if (take) begin
          best_d      = dist_q;
          near_band_d = idx_q[BAND_IDX_W-1:0];
          found_d     = 1'b1;
        end
        if (!(cmp_floor_q && !rd.ceil_open)) idx_d = idx_q + 1'b1;
      end
      ST_DIV_INIT: begin
        // buffer - distance, must be positive to blend
        cmp_a  = sext_h(rd.buffer);
        cmp_b  = zext_d(best_q);
        rem_d  = cmp.diff[DIST_W-1:0];
        quot_d = '0;
        step_d = '0;
      end
      ST_DIV_STEP: begin
        // first step tests for a full weight of one, then one bit per cycle
        cmp_a = (step_q == '0) ? zext_d(rem_q) : zext_d({rem_q[DIST_W-2:0], 1'b0});
        cmp_b = sext_h(rd.buffer);
        if (!cmp.lt) begin
          rem_d = cmp.diff[DIST_W-1:0];
        end else begin
          rem_d = cmp_a[DIST_W-1:0];
        end
        quot_d = {quot_q[WEIGHT_W-2:0], !cmp.lt};
        step_d = step_q + 1'b1;
        if (step_last) nb_valid_d = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.pad             = '0;
          out_d.primary_band    = primary_q;
          out_d.instant_cut     = cut_q;
          out_d.neighbor_valid  = nb_valid_q;
          out_d.neighbor_band   = nb_valid_q ? near_band_q : '0;
          out_d.neighbor_weight = nb_valid_q ? quot_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      step_q      <= '0;
      nb_valid_q  <= 1'b0;
      found_q     <= 1'b0;
      cut_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      step_q      <= step_d;
      nb_valid_q  <= nb_valid_d;
      found_q     <= found_d;
      cut_q       <= cut_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q         <= h_d;
    ph_q        <= ph_d;
    ph_ge_q     <= ph_ge_d;
    primary_q   <= primary_d;
    best_q      <= best_d;
    near_band_q <= near_band_d;
    dist_q      <= dist_d;
    cmp_floor_q <= cmp_floor_d;
    rem_q       <= rem_d;
    quot_q      <= quot_d;
    out_q       <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule
